/* design/baeq_pkg.sv */
// Package for the button auto-repeat event queue.
// Holds shared widths, codes, reset values and the lane result type.
// Depends on nothing; compile first.
package baeq_pkg;

    localparam int NUM_BUTTONS         = 5;
    localparam int COUNT_W             = 16;
    localparam int CODE_W              = 3;
    localparam int LEVEL_W             = NUM_BUTTONS;
    localparam int RANK_W              = 3;
    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [COUNT_W-1:0] HOLD_RESET   = 16'd50;
    localparam logic [COUNT_W-1:0] REPEAT_RESET = 16'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic REG_HOLD   = 1'b0;
    localparam logic REG_REPEAT = 1'b1;

    typedef struct packed {
        logic               held;
        logic               cand;
        logic [COUNT_W-1:0] cnt_plain;
        logic [COUNT_W-1:0] cnt_push;
    } lane_res_t;

endpackage

/* design/baeq_in_if.sv */
// Input channel of the button auto-repeat event queue: valid, ready and one item.
// Depends on baeq_pkg.
interface baeq_in_if;
    import baeq_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [LEVEL_W-1:0] button_levels;

    modport source (output valid, output kind, output button_levels, input ready);
    modport sink   (input valid, input kind, input button_levels, output ready);
endinterface

/* design/baeq_out_if.sv */
// Result channel of the button auto-repeat event queue: valid, ready and one result.
// Depends on baeq_pkg.
interface baeq_out_if;
    import baeq_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pressed_mask;
    logic [CODE_W-1:0]  press_code;
    logic               queue_full;
    logic               queue_empty;

    modport source (output valid, output pressed_mask, output press_code,
                    output queue_full, output queue_empty, input ready);
    modport sink   (input valid, input pressed_mask, input press_code,
                    input queue_full, input queue_empty, output ready);
endinterface

/* design/baeq_lane.sv */
// One button lane: next hold count, press candidate and post-repeat count.
// Depends on baeq_pkg.
module baeq_lane (
    input  logic                       pressed,
    input  logic [baeq_pkg::COUNT_W-1:0] count,
    input  logic [baeq_pkg::COUNT_W-1:0] hold_ticks,
    input  logic [baeq_pkg::COUNT_W-1:0] rpt_ticks,
    output baeq_pkg::lane_res_t        res
);
    import baeq_pkg::*;

    logic [COUNT_W-1:0] c_new;

    always_comb
    begin
        // saturating count while held, clear on release
        if (!pressed)
            c_new = '0;
        else if (count == COUNT_MAX)
            c_new = count;
        else
            c_new = count + 1'b1;

        res.held      = pressed;
        res.cand      = (c_new == COUNT_W'(1)) || (c_new > hold_ticks);
        res.cnt_plain = c_new;
        if (c_new > COUNT_W'(1))
            res.cnt_push = (c_new > rpt_ticks) ? (c_new - rpt_ticks) : '0;
        else
            res.cnt_push = c_new;
    end
endmodule

/* design/baeq_merge.sv */
// Merge stage: grants lane presses in button order against free queue space.
// Depends on baeq_pkg.
module baeq_merge #(
    parameter int QUEUE_DEPTH = baeq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic [baeq_pkg::NUM_BUTTONS-1:0]                         cand,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]                           wr_idx,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]                         fill,
    output logic [baeq_pkg::NUM_BUTTONS-1:0]                         grant,
    output logic [baeq_pkg::NUM_BUTTONS-1:0][$clog2(QUEUE_DEPTH)-1:0] pos,
    output logic [$clog2(QUEUE_DEPTH)-1:0]                           wr_next,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]                         fill_next
);
    import baeq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = ((IDX_W > RANK_W) ? IDX_W : RANK_W) + 1;
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    logic [CNT_W-1:0] free_slots;

    always_comb
    begin
        logic [RANK_W-1:0] rank;
        logic [SUM_W-1:0]  sum;

        free_slots = CNT_W'(QUEUE_DEPTH) - fill;
        rank       = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            // slot offset is the number of earlier candidates
            sum = SUM_W'(wr_idx) + SUM_W'(rank);
            if (sum >= SUM_W'(QUEUE_DEPTH))
                sum = sum - SUM_W'(QUEUE_DEPTH);
            pos[i]   = sum[IDX_W-1:0];
            grant[i] = cand[i] && (CMP_W'(rank) < CMP_W'(free_slots));
            if (cand[i])
                rank = rank + 1'b1;
        end

        // granted count is the lesser of candidates and free slots
        if (CMP_W'(rank) > CMP_W'(free_slots))
            rank = RANK_W'(free_slots);

        sum = SUM_W'(wr_idx) + SUM_W'(rank);
        if (sum >= SUM_W'(QUEUE_DEPTH))
            sum = sum - SUM_W'(QUEUE_DEPTH);
        wr_next   = sum[IDX_W-1:0];
        fill_next = fill + CNT_W'(rank);
    end
endmodule

/* design/button_autorepeat_event_queue.sv */
// Button auto-repeat event queue. Each input word is either a tick carrying five
// active-low button levels or a pop. On a tick, five parallel lanes update the hold
// counts of the buttons; a lane raises a press on the first held tick and whenever
// its count passes hold_ticks, and the merge stage grants those presses in button
// order into a ring queue of QUEUE_DEPTH codes (code = button index plus one)
// until the queue is full, after which presses are dropped. Granted repeats lower
// the count by repeat_ticks, stopping at zero. A pop returns the oldest code, or 0
// on an empty queue. Every input word yields one result word: the held mask, the
// popped code and the full and empty flags after the word. Rate: one word per
// clock while ready is high, with combinational lane update and merge; each result
// is registered in the output buffer when its word is accepted. Two words deep, it lets
// input continue while one result waits, and ready drops only while both are occupied.
// The registers hold_ticks (address 0) and repeat_ticks (address 4) sit on the APB
// port, which never waits; write them only while the block is idle.
module button_autorepeat_event_queue #(
    parameter int QUEUE_DEPTH = baeq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    baeq_in_if.sink                         in_ch,
    baeq_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [baeq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [baeq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [baeq_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import baeq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [LEVEL_W-1:0] pressed_mask;
        logic [CODE_W-1:0]  press_code;
        logic               queue_full;
        logic               queue_empty;
    } result_t;

    // configuration
    logic [COUNT_W-1:0] hold_reg;
    logic [COUNT_W-1:0] rpt_reg;
    logic               cfg_wr;

    // per-button and queue state
    logic [COUNT_W-1:0] cnt_reg [NUM_BUTTONS];
    logic [LEVEL_W-1:0] held_reg;
    logic [CODE_W-1:0]  store_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_reg;
    logic [IDX_W-1:0]   rd_reg;
    logic [CNT_W-1:0]   fill_reg;

    // lane and merge results
    lane_res_t                           lane_res [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]              cand;
    logic [NUM_BUTTONS-1:0]              grant;
    logic [NUM_BUTTONS-1:0][IDX_W-1:0]   pos;
    logic [IDX_W-1:0]                    merge_wr;
    logic [CNT_W-1:0]                    merge_fill;

    // item decode and next state
    logic               accept;
    logic               is_tick;
    logic               pop_ok;
    logic [LEVEL_W-1:0] held_next;
    logic [IDX_W-1:0]   wr_next;
    logic [IDX_W-1:0]   rd_next;
    logic [CNT_W-1:0]   fill_next;
    result_t            res_new;

    // output buffer
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    out_pop;

    // ---------------------------------------------------------------- config
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'((paddr[APB_ADDR_W-1] == REG_REPEAT) ? rpt_reg : hold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
            rpt_reg  <= REPEAT_RESET;
        end
        else if (cfg_wr)
        begin
            // upper data bits are ignored
            if (paddr[APB_ADDR_W-1] == REG_HOLD)
                hold_reg <= pwdata[COUNT_W-1:0];
            else
                rpt_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- lanes
    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_lane
        baeq_lane u_lane (
            .pressed    (~in_ch.button_levels[g]),
            .count      (cnt_reg[g]),
            .hold_ticks (hold_reg),
            .rpt_ticks  (rpt_reg),
            .res        (lane_res[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            cand[i]      = lane_res[i].cand;
            held_next[i] = lane_res[i].held;
        end
    end

    baeq_merge #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_merge (
        .cand      (cand),
        .wr_idx    (wr_reg),
        .fill      (fill_reg),
        .grant     (grant),
        .pos       (pos),
        .wr_next   (merge_wr),
        .fill_next (merge_fill)
    );

    // ---------------------------------------------------------------- queue
    assign accept  = in_ch.valid && in_ch.ready;
    assign is_tick = (in_ch.kind == KIND_TICK);
    assign pop_ok  = !is_tick && (fill_reg != '0);
    assign rd_next = (rd_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;

    always_comb
    begin
        wr_next   = wr_reg;
        fill_next = fill_reg;
        if (is_tick)
        begin
            wr_next   = merge_wr;
            fill_next = merge_fill;
        end
        else if (pop_ok)
            fill_next = fill_reg - 1'b1;

        res_new.pressed_mask = is_tick ? held_next : held_reg;
        res_new.press_code   = pop_ok ? store_reg[rd_reg] : '0;
        res_new.queue_full   = (fill_next == CNT_W'(QUEUE_DEPTH));
        res_new.queue_empty  = (fill_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
                cnt_reg[i] <= '0;
            held_reg <= '0;
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wr_reg   <= wr_next;
            fill_reg <= fill_next;
            if (is_tick)
            begin
                held_reg <= held_next;
                // granted repeats take the reduced count; lost presses keep theirs
                for (int i = 0; i < NUM_BUTTONS; i++)
                    cnt_reg[i] <= grant[i] ? lane_res[i].cnt_push : lane_res[i].cnt_plain;
            end
            else if (pop_ok)
                rd_reg <= rd_next;
        end
    end

    // code store: no reset, entries are read only after being written
    always_ff @(posedge clk)
    begin
        if (accept && is_tick)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (grant[i])
                    store_reg[pos[i]] <= CODE_W'(i + 1);
            end
        end
    end

    // ---------------------------------------------------------------- output
    // Hold the head result in out_reg; park a second one in skid_reg while stalled.
    assign out_pop     = out_valid_reg && out_ch.ready;
    assign in_ch.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_reg       <= res_new;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= res_new;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pressed_mask = out_reg.pressed_mask;
    assign out_ch.press_code   = out_reg.press_code;
    assign out_ch.queue_full   = out_reg.queue_full;
    assign out_ch.queue_empty  = out_reg.queue_empty;
endmodule

/* design/baeq_checker.sv */
// Port-level checks for the button auto-repeat event queue, bound to the top level.
// Depends on baeq_pkg and button_autorepeat_event_queue.
module baeq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [baeq_pkg::LEVEL_W-1:0]  pressed_mask,
    input logic [baeq_pkg::CODE_W-1:0]   press_code,
    input logic                          queue_full,
    input logic                          queue_empty
);
    import baeq_pkg::*;

    // hold a stalled result steady
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressed_mask)
            && $stable(press_code) && $stable(queue_full) && $stable(queue_empty))
        else $error("stalled result changed");

    // a queue is never full and empty at once
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(queue_full && queue_empty))
        else $error("queue full and empty together");

    // a successful pop leaves room behind it
    a_pop_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (press_code != '0) |-> !queue_full)
        else $error("full after a pop");

    // only button codes leave the queue
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (press_code <= CODE_W'(NUM_BUTTONS)))
        else $error("press code out of range");

    // input backs up only behind a held result
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind button_autorepeat_event_queue baeq_checker u_baeq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .pressed_mask (out_ch.pressed_mask),
    .press_code   (out_ch.press_code),
    .queue_full   (out_ch.queue_full),
    .queue_empty  (out_ch.queue_empty)
);
